FILE: hw/rtl/offset_arc_corner_collapse_defines.svh
// Assertion macros for the offset arc corner collapse block.
// Used by the top level; expects clk and rst in scope.
`ifndef OFFSET_ARC_CORNER_COLLAPSE_DEFINES_SVH
`define OFFSET_ARC_CORNER_COLLAPSE_DEFINES_SVH
`ifndef SYNTHESIS
`define OACC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oacc check failed");
`define OACC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("oacc check failed");
`else
`define OACC_ASSERT_IMPLY(lbl, ante, cons)
`define OACC_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hw/rtl/oacc_pkg.sv
// Shared widths, types and tables of the offset arc corner collapse block.
// No dependencies.
package oacc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int THR_W = 30;
  localparam logic [THR_W-1:0] THR_RESET = 30'd10737;

  localparam int CW   = 32;
  localparam int RW   = 31;
  localparam int AGW  = 16;
  localparam int TW   = 16;
  localparam int XW   = 34;
  localparam int ZW   = 33;
  localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;

  localparam int PW   = 35;
  localparam int DFW  = 36;
  localparam int MW   = 52;
  localparam int NW   = 38;
  localparam int QW   = NW + TW;
  localparam int DETW = 32;
  localparam int DVW  = 31;
  localparam int DIV_FRAC = 15;
  localparam int DIV_QB   = 37;
  localparam int DIV_SH   = DIV_QB - DIV_FRAC;

  typedef struct packed {
    logic                  collapse;
    logic                  sg_neg;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic [RW-1:0]         r;
    logic signed [CW-1:0]  off;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic signed [TW-1:0]  s0;
    logic signed [TW-1:0]  c0;
    logic signed [TW-1:0]  s1;
    logic signed [TW-1:0]  c1;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic signed [ZW-1:0] atan_at(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 33'sd536870912;
      1:  v = 33'sd316933406;
      2:  v = 33'sd167458907;
      3:  v = 33'sd85004756;
      4:  v = 33'sd42667331;
      5:  v = 33'sd21354465;
      6:  v = 33'sd10679838;
      7:  v = 33'sd5340245;
      8:  v = 33'sd2670163;
      9:  v = 33'sd1335087;
      10: v = 33'sd667544;
      11: v = 33'sd333772;
      12: v = 33'sd166886;
      13: v = 33'sd83443;
      14: v = 33'sd41722;
      15: v = 33'sd20861;
      16: v = 33'sd10430;
      17: v = 33'sd5215;
      18: v = 33'sd2608;
      19: v = 33'sd1304;
      20: v = 33'sd652;
      21: v = 33'sd326;
      22: v = 33'sd163;
      23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/oacc_if.sv
// Segment request and corner result channel interfaces.
// Depends on oacc_pkg.
interface oacc_seg_if import oacc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 is_arc;
  logic signed [CW-1:0] pivot_x;
  logic signed [CW-1:0] pivot_y;
  logic [RW-1:0]        arc_radius;
  logic signed [AGW-1:0] start_angle;
  logic signed [AGW-1:0] end_angle;
  logic signed [CW-1:0] side_offset;

  modport source (output valid, is_arc, pivot_x, pivot_y, arc_radius, start_angle,
                  end_angle, side_offset, input ready);
  modport sink (input valid, is_arc, pivot_x, pivot_y, arc_radius, start_angle,
                end_angle, side_offset, output ready);
endinterface

interface oacc_res_if import oacc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 collapsed;
  logic signed [CW-1:0] corner_x;
  logic signed [CW-1:0] corner_y;
  logic                 used_center;

  modport source (output valid, collapsed, corner_x, corner_y, used_center, input ready);
  modport sink (input valid, collapsed, corner_x, corner_y, used_center, output ready);
endinterface

FILE: hw/rtl/offset_arc_corner_collapse.sv
// Top level of the offset arc corner collapse block: threshold register,
// front end, request queue and back end. Depends on oacc_pkg, oacc_if and submodules.
//
//   channel   role   carries
//   seg       sink   is_arc, pivot_x/y, arc_radius, start/end_angle, side_offset
//   res       source collapsed, corner_x/y, used_center
//   cfg_wr_*  write  parallel_threshold
//
// One request per cycle sustained while res.ready stays high; one result per request, in order.
// Path: front end with both CORDICs, queue, then back end, which ends in the
// 37-stage one-bit-per-stage divider and an output register.
// Reset clears all valid bits and the queue and loads the threshold with 10737.
// res.ready low holds the back end; the front end fills the queue, then drops seg.ready.
`include "offset_arc_corner_collapse_defines.svh"
module offset_arc_corner_collapse import oacc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  oacc_seg_if.sink         seg,
  oacc_res_if.source       res,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  logic [THR_W-1:0] thr;
  logic             f_valid;
  logic             f_ready;
  item_t            f_item;
  logic             q_valid;
  logic             q_ready;
  item_t            q_item;
  queue_stat_t      q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  oacc_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .seg       (seg),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  oacc_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item),
    .stat      (q_stat)
  );

  oacc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_item  (q_item),
    .thr      (thr),
    .res      (res)
  );

  `OACC_ASSERT_IMPLY(a_center_is_collapse, res.valid && res.used_center, res.collapsed)
  `OACC_ASSERT_IMPLY(a_open_arc_zero, res.valid && !res.collapsed, res.corner_x == '0 && res.corner_y == '0 && !res.used_center)
  `OACC_ASSERT_NEVER(a_queue_state, q_stat.full && q_stat.empty)

endmodule

FILE: hw/rtl/oacc_cordic.sv
// Pipelined rotation CORDIC giving Q1.15 sine and cosine of a binary angle.
// Depends on oacc_pkg; input register, rotation stages and output register all advance on en.
module oacc_cordic import oacc_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AGW-1:0] angle,
  output logic signed [TW-1:0]  sin_q,
  output logic signed [TW-1:0]  cos_q
);

  logic signed [XW-1:0] x [0:STEPS];
  logic signed [XW-1:0] y [0:STEPS];
  logic signed [ZW-1:0] z [0:STEPS];
  logic                 flip [0:STEPS];
  logic signed [ZW-1:0] z_in;
  logic                 flip_in;
  logic signed [TW-1:0] xs_q15;
  logic signed [TW-1:0] ys_q15;

  function automatic logic signed [TW-1:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(1 << 14)) >>> 15;
    if (r > XW'(32767)) return 16'sd32767;
    if (r < -XW'(32767)) return -16'sd32767;
    return TW'(r);
  endfunction

  always_comb begin
    flip_in = (angle > 16'sd16384) || (angle < -16'sd16384);
    z_in = ZW'(signed'({angle[AGW-1] ^ flip_in, angle[AGW-2:0], 16'h0000}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CORDIC_K;
      y[0]    <= '0;
      z[0]    <= z_in;
      flip[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    assign xsh = x[i] >>> i;
    assign ysh = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - ysh;
          y[i+1] <= y[i] + xsh;
          z[i+1] <= z[i] - atan_at(i);
        end else begin
          x[i+1] <= x[i] + ysh;
          y[i+1] <= y[i] - xsh;
          z[i+1] <= z[i] + atan_at(i);
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  assign xs_q15 = to_q15(x[STEPS]);
  assign ys_q15 = to_q15(y[STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= flip[STEPS] ? -xs_q15 : xs_q15;
      sin_q <= flip[STEPS] ? -ys_q15 : ys_q15;
    end
  end

endmodule

FILE: hw/rtl/oacc_front.sv
// Front end: accepts segment requests, decides collapse, runs both CORDICs.
// Depends on oacc_pkg, oacc_if and oacc_cordic.
module oacc_front import oacc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  oacc_seg_if.sink    seg,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item
);

  localparam int DEPTH = CORDIC_STEPS + 2;

  logic [DEPTH-1:0]      vld;
  side_t                 side [0:DEPTH-1];
  side_t                 side_in;
  logic                  adv;
  logic signed [CW+1:0]  reach;
  logic signed [TW-1:0]  s0, c0, s1, c1;

  assign adv       = !vld[DEPTH-1] || out_ready;
  assign seg.ready = adv;

  always_comb begin
    side_in.sg_neg = seg.end_angle < seg.start_angle;
    reach = (CW+2)'(signed'({1'b0, seg.arc_radius}))
          + (side_in.sg_neg ? -((CW+2)'(seg.side_offset)) : (CW+2)'(seg.side_offset));
    side_in.collapse = seg.is_arc && (reach[CW+1] || reach == '0);
    side_in.cx  = seg.pivot_x;
    side_in.cy  = seg.pivot_y;
    side_in.r   = seg.arc_radius;
    side_in.off = seg.side_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], seg.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int j = 1; j < DEPTH; j++) begin
        side[j] <= side[j-1];
      end
    end
  end

  oacc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_start (
    .clk   (clk),
    .en    (adv),
    .angle (seg.start_angle),
    .sin_q (s0),
    .cos_q (c0)
  );

  oacc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_end (
    .clk   (clk),
    .en    (adv),
    .angle (seg.end_angle),
    .sin_q (s1),
    .cos_q (c1)
  );

  assign out_valid     = vld[DEPTH-1];
  assign out_item.side = side[DEPTH-1];
  assign out_item.s0   = s0;
  assign out_item.c0   = c0;
  assign out_item.s1   = s1;
  assign out_item.c1   = c1;

endmodule

FILE: hw/rtl/oacc_fifo.sv
// Short queue of classified requests between front and back end.
// Depends on oacc_pkg.
module oacc_fifo import oacc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item,
  output queue_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t          mem [0:DEPTH-1];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;

  assign in_ready   = count != (AW+1)'(DEPTH);
  assign out_valid  = count != '0;
  assign push       = in_valid && in_ready;
  assign pop        = out_valid && out_ready;
  assign out_item   = mem[rd_ptr];
  assign stat.full  = !in_ready;
  assign stat.empty = !out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/oacc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on oacc_pkg; every stage register advances only when en is high.
module oacc_div import oacc_pkg::*; #(
  parameter int QB = DIV_QB
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] rem_in,
  input  logic [QB-1:0]  low_in,
  input  logic [DVW-1:0] den_in,
  output logic [QB-1:0]  quo
);

  logic [DVW-1:0] rem_q [0:QB-1];
  logic [QB-1:0]  low_q [0:QB-1];
  logic [DVW-1:0] den_q [0:QB-1];
  logic [QB-1:0]  quo_q [0:QB-1];

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [DVW-1:0] rp;
    logic [DVW-1:0] dp;
    logic [QB-1:0]  lp;
    logic [QB-1:0]  qp;
    logic [DVW:0]   trial;
    logic           ge;
    if (j == 0) begin : g_first
      assign rp = rem_in;
      assign dp = den_in;
      assign lp = low_in;
      assign qp = '0;
    end else begin : g_next
      assign rp = rem_q[j-1];
      assign dp = den_q[j-1];
      assign lp = low_q[j-1];
      assign qp = quo_q[j-1];
    end
    assign trial = {rp, lp[QB-1]};
    assign ge    = trial >= {1'b0, dp};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? DVW'(trial - {1'b0, dp}) : DVW'(trial);
        low_q[j] <= lp << 1;
        den_q[j] <= dp;
        quo_q[j] <= {qp[QB-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QB-1];

endmodule

FILE: hw/rtl/oacc_back.sv
// Back end: tangents, offset end points, line intersection and saturation, or the center point.
// Depends on oacc_pkg, oacc_if and oacc_div.
module oacc_back import oacc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  logic [THR_W-1:0] thr,
  oacc_res_if.source       res
);

  localparam int BL  = DIV_QB + 8;
  localparam int PSW = 50;
  localparam int MSW = MW + 1;
  localparam int SW  = DIV_QB + 1;
  localparam int FW  = SW + 2;

  typedef struct packed {
    logic                 collapse;
    logic                 used;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [PW-1:0] pa;
    logic signed [PW-1:0] pb;
    logic                 negx;
    logic                 negy;
    logic                 ovfx;
    logic                 ovfy;
  } sb_t;

  logic [BL-1:0] vld;
  logic          adv;

  // stage 1
  item_t                it1;
  logic signed [TW-1:0] tx0, ty0, tx1, ty1;
  // stage 2
  side_t                sd2;
  logic signed [TW-1:0] tx0_2, ty0_2, tx1_2, ty1_2;
  logic signed [31:0]   pda, pdb;
  logic signed [47:0]   rc0, rs0, rc1, rs1, oty0, otx0, oty1, otx1;
  // stage 3
  side_t                sd3;
  logic signed [TW-1:0] tx0_3, ty0_3, tx1_3, ty1_3;
  logic signed [DETW-1:0] det3;
  logic                 used3;
  logic signed [PW-1:0] pa3, pb3, pc3, pd3;
  logic signed [DETW-1:0] det_c;
  logic [DVW-1:0]       adet_c;
  logic signed [PSW-1:0] sa, sb, sc, sd;
  // stage 4
  side_t                sd4;
  logic signed [TW-1:0] tx0_4, ty0_4;
  logic signed [DETW-1:0] det4;
  logic                 used4;
  logic signed [PW-1:0] pa4, pb4;
  logic signed [MW-1:0] m1, m2;
  logic signed [DFW-1:0] dac, dbd;
  // stage 5
  side_t                sd5;
  logic signed [TW-1:0] tx0_5, ty0_5;
  logic signed [DETW-1:0] det5;
  logic                 used5;
  logic signed [PW-1:0] pa5, pb5;
  logic signed [NW-1:0] num5;
  // stage 6
  side_t                sd6;
  logic signed [DETW-1:0] det6;
  logic                 used6;
  logic signed [PW-1:0] pa6, pb6;
  logic signed [QW-1:0] qx6, qy6;
  // stage 7
  logic [QW-1:0]        aqx, aqy;
  logic [DVW-1:0]       adet6;
  sb_t                  sb7_c, sb7;
  logic [DVW-1:0]       remx7, remy7, den7;
  logic [DIV_QB-1:0]    lowx7, lowy7;
  // divider and final
  sb_t                  sbq [0:DIV_QB-1];
  sb_t                  sbl;
  logic [DIV_QB-1:0]    quox, quoy;
  logic signed [CW-1:0] fx, fy;

  function automatic logic signed [CW-1:0] corner(input logic signed [PW-1:0] p,
                                                 input logic [DIV_QB-1:0] q,
                                                 input logic neg, input logic ovf);
    logic [DIV_QB-1:0]    mag;
    logic signed [SW-1:0] sq;
    logic signed [FW-1:0] sum;
    mag = ovf ? (DIV_QB'(1) << (DIV_QB - 1)) : q;
    sq  = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    sum = FW'(p) + FW'(sq);
    if (sum > FW'(64'sd2147483647)) return 32'sh7fffffff;
    if (sum < -FW'(64'sd2147483648)) return 32'sh80000000;
    return CW'(sum);
  endfunction

  assign adv      = !vld[BL-1] || res.ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[BL-2:0], in_valid};
    end
  end

  always_comb begin
    tx0 = it1.side.sg_neg ? it1.s0 : -it1.s0;
    ty0 = it1.side.sg_neg ? -it1.c0 : it1.c0;
    tx1 = it1.side.sg_neg ? it1.s1 : -it1.s1;
    ty1 = it1.side.sg_neg ? -it1.c1 : it1.c1;
  end

  always_comb begin
    det_c  = pda - pdb;
    adet_c = det_c[DETW-1] ? DVW'(-det_c) : DVW'(det_c);
    sa = (PSW'(sd2.cx) <<< 15) + PSW'(rc0) + PSW'(oty0) + PSW'(1 << 14);
    sb = (PSW'(sd2.cy) <<< 15) + PSW'(rs0) - PSW'(otx0) + PSW'(1 << 14);
    sc = (PSW'(sd2.cx) <<< 15) + PSW'(rc1) + PSW'(oty1) + PSW'(1 << 14);
    sd = (PSW'(sd2.cy) <<< 15) + PSW'(rs1) - PSW'(otx1) + PSW'(1 << 14);
    dac = DFW'(pc3) - DFW'(pa3);
    dbd = DFW'(pd3) - DFW'(pb3);
  end

  always_comb begin
    aqx   = qx6[QW-1] ? QW'(-qx6) : QW'(qx6);
    aqy   = qy6[QW-1] ? QW'(-qy6) : QW'(qy6);
    adet6 = det6[DETW-1] ? DVW'(-det6) : DVW'(det6);
    sb7_c.collapse = sd6.collapse;
    sb7_c.used     = used6;
    sb7_c.cx       = sd6.cx;
    sb7_c.cy       = sd6.cy;
    sb7_c.pa       = pa6;
    sb7_c.pb       = pb6;
    sb7_c.negx     = qx6[QW-1] ^ det6[DETW-1];
    sb7_c.negy     = qy6[QW-1] ^ det6[DETW-1];
    sb7_c.ovfx     = aqx[QW-1:DIV_SH] >= (QW-DIV_SH)'(adet6);
    sb7_c.ovfy     = aqy[QW-1:DIV_SH] >= (QW-DIV_SH)'(adet6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1 <= in_item;

      sd2   <= it1.side;
      tx0_2 <= tx0;
      ty0_2 <= ty0;
      tx1_2 <= tx1;
      ty1_2 <= ty1;
      pda   <= tx0 * ty1;
      pdb   <= ty0 * tx1;
      rc0   <= signed'({1'b0, it1.side.r}) * it1.c0;
      rs0   <= signed'({1'b0, it1.side.r}) * it1.s0;
      rc1   <= signed'({1'b0, it1.side.r}) * it1.c1;
      rs1   <= signed'({1'b0, it1.side.r}) * it1.s1;
      oty0  <= ty0 * it1.side.off;
      otx0  <= tx0 * it1.side.off;
      oty1  <= ty1 * it1.side.off;
      otx1  <= tx1 * it1.side.off;

      sd3   <= sd2;
      tx0_3 <= tx0_2;
      ty0_3 <= ty0_2;
      tx1_3 <= tx1_2;
      ty1_3 <= ty1_2;
      det3  <= det_c;
      used3 <= {1'b0, adet_c} <= {1'b0, thr};
      pa3   <= PW'(sa >>> 15);
      pb3   <= PW'(sb >>> 15);
      pc3   <= PW'(sc >>> 15);
      pd3   <= PW'(sd >>> 15);

      sd4   <= sd3;
      tx0_4 <= tx0_3;
      ty0_4 <= ty0_3;
      det4  <= det3;
      used4 <= used3;
      pa4   <= pa3;
      pb4   <= pb3;
      m1    <= dac * ty1_3;
      m2    <= dbd * tx1_3;

      sd5   <= sd4;
      tx0_5 <= tx0_4;
      ty0_5 <= ty0_4;
      det5  <= det4;
      used5 <= used4;
      pa5   <= pa4;
      pb5   <= pb4;
      num5  <= NW'((MSW'(m1) - MSW'(m2) + MSW'(1 << 14)) >>> 15);

      sd6   <= sd5;
      det6  <= det5;
      used6 <= used5;
      pa6   <= pa5;
      pb6   <= pb5;
      qx6   <= num5 * tx0_5;
      qy6   <= num5 * ty0_5;

      sb7   <= sb7_c;
      remx7 <= DVW'(aqx[QW-1:DIV_SH]);
      remy7 <= DVW'(aqy[QW-1:DIV_SH]);
      lowx7 <= {aqx[DIV_SH-1:0], DIV_FRAC'(0)};
      lowy7 <= {aqy[DIV_SH-1:0], DIV_FRAC'(0)};
      den7  <= adet6;

      sbq[0] <= sb7;
      for (int j = 1; j < DIV_QB; j++) begin
        sbq[j] <= sbq[j-1];
      end
    end
  end

  oacc_div #(.QB(DIV_QB)) u_div_x (
    .clk    (clk),
    .en     (adv),
    .rem_in (remx7),
    .low_in (lowx7),
    .den_in (den7),
    .quo    (quox)
  );

  oacc_div #(.QB(DIV_QB)) u_div_y (
    .clk    (clk),
    .en     (adv),
    .rem_in (remy7),
    .low_in (lowy7),
    .den_in (den7),
    .quo    (quoy)
  );

  assign sbl = sbq[DIV_QB-1];
  assign fx  = corner(sbl.pa, quox, sbl.negx, sbl.ovfx);
  assign fy  = corner(sbl.pb, quoy, sbl.negy, sbl.ovfy);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!sbl.collapse) begin
        res.collapsed   <= 1'b0;
        res.corner_x    <= '0;
        res.corner_y    <= '0;
        res.used_center <= 1'b0;
      end else if (sbl.used) begin
        res.collapsed   <= 1'b1;
        res.corner_x    <= sbl.cx;
        res.corner_y    <= sbl.cy;
        res.used_center <= 1'b1;
      end else begin
        res.collapsed   <= 1'b1;
        res.corner_x    <= fx;
        res.corner_y    <= fy;
        res.used_center <= 1'b0;
      end
    end
  end

  assign res.valid = vld[BL-1];

endmodule

FILE: bench/oacc_corner_checker.sv
// Corner checker: predicts the corner result of every accepted segment request
// and compares it with the result channel. Depends on oacc_pkg and oacc_if.
`timescale 1ns / 100ps
module oacc_corner_checker import oacc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  oacc_seg_if              seg,
  oacc_res_if              res,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  output int               errors,
  output int               pending
);

  typedef struct {
    logic                 collapsed;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 used_center;
  } corner_t;

  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic [THR_W-1:0] thr;
  corner_t          corners_due[$];

  function automatic void angle_sincos(input logic [AGW-1:0] a, output longint s,
                                       output longint c);
    logic [31:0] u;
    longint x, y, z, t;
    bit flip;
    u = {a, 16'h0};
    flip = 0;
    x = 652032874;
    y = 0;
    z = longint'($signed(u));
    if (z > 1073741824 || z < -1073741824) begin
      u[31] = ~u[31];
      z = longint'($signed(u));
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ARCTAN[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += ARCTAN[i];
      end
    end
    x = (x + 16384) >>> 15;
    y = (y + 16384) >>> 15;
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint scaled_quot(input longint q, input longint d);
    longint hi, rem;
    hi = q / d;
    rem = q % d;
    if (hi > 64'sd8589934592) return 64'sd281474976710656;
    if (hi < -64'sd8589934592) return -64'sd281474976710656;
    return hi * 32768 + (rem * 32768) / d;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic corner_t predict_corner(input logic arc, input longint cx, cy, r,
                                             input logic [AGW-1:0] a0, a1,
                                             input longint off, input longint limit);
    corner_t res_c;
    longint sg, s0, c0, s1, c1, tx0, ty0, tx1, ty1, det, pa, pb, pc, pd, num;
    res_c = '{1'b0, '0, '0, 1'b0};
    sg = ($signed(a1) >= $signed(a0)) ? 1 : -1;
    if (!arc || r + sg * off > 0) return res_c;
    angle_sincos(a0, s0, c0);
    angle_sincos(a1, s1, c1);
    tx0 = -s0 * sg; ty0 = c0 * sg;
    tx1 = -s1 * sg; ty1 = c1 * sg;
    det = tx0 * ty1 - ty0 * tx1;
    res_c.collapsed = 1'b1;
    if ((det < 0 ? -det : det) <= limit) begin
      res_c.x = cx[31:0];
      res_c.y = cy[31:0];
      res_c.used_center = 1'b1;
      return res_c;
    end
    pa = (cx * 32768 + r * c0 + ty0 * off + 16384) >>> 15;
    pb = (cy * 32768 + r * s0 - tx0 * off + 16384) >>> 15;
    pc = (cx * 32768 + r * c1 + ty1 * off + 16384) >>> 15;
    pd = (cy * 32768 + r * s1 - tx1 * off + 16384) >>> 15;
    num = ((pc - pa) * ty1 - (pd - pb) * tx1 + 16384) >>> 15;
    res_c.x = CW'(clamp32(pa + scaled_quot(num * tx0, det)));
    res_c.y = CW'(clamp32(pb + scaled_quot(num * ty0, det)));
    return res_c;
  endfunction

  assign pending = corners_due.size();

  always @(posedge clk) begin
    corner_t want;
    if (rst) begin
      thr <= THR_RESET;
      errors <= 0;
      corners_due.delete();
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (seg.valid && seg.ready)
        corners_due.push_back(predict_corner(seg.is_arc, longint'(seg.pivot_x),
          longint'(seg.pivot_y), longint'({1'b0, seg.arc_radius}), seg.start_angle,
          seg.end_angle, longint'(seg.side_offset), longint'({1'b0, thr})));
      if (res.valid && res.ready) begin
        if (corners_due.size() == 0) begin
          if (errors < 10) $display("unexpected corner result at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = corners_due.pop_front();
          if (res.collapsed !== want.collapsed || res.corner_x !== want.x ||
              res.corner_y !== want.y || res.used_center !== want.used_center) begin
            if (errors < 10)
              $display("corner mismatch at %0t: want %b %0d %0d %b, got %b %0d %0d %b",
                       $realtime, want.collapsed, want.x, want.y, want.used_center,
                       res.collapsed, res.corner_x, res.corner_y, res.used_center);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_top.sv
// Top of the corner collapse bench: clock, reset, segment requests, result
// stalls, threshold writes and the verdict. Depends on oacc_pkg, oacc_if, the checker.
`timescale 1ns / 100ps
module tb_top;
  import oacc_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;
  logic             seg_took;
  bit               quiet;
  int               errors;
  int               pending;

  oacc_seg_if seg_ch ();
  oacc_res_if res_ch ();

  offset_arc_corner_collapse uut (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg_ch),
    .res        (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  oacc_corner_checker chk (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg_ch),
    .res        (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) seg_took <= seg_ch.valid && seg_ch.ready;

  initial begin
    int hold;
    hold = 0;
    res_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        res_ch.ready = 1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        res_ch.ready = 0;
        hold = $urandom_range(1, 12) - 1;
      end else begin
        res_ch.ready = 1;
        hold = $urandom_range(0, 20);
      end
    end
  end

  task automatic send_seg(input logic arc, input logic [31:0] cx, cy,
                          input logic [30:0] r, input logic [15:0] a0, a1,
                          input logic [31:0] off);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      seg_ch.valid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    seg_ch.valid = 1;
    seg_ch.is_arc = arc;
    seg_ch.pivot_x = cx;
    seg_ch.pivot_y = cy;
    seg_ch.arc_radius = r;
    seg_ch.start_angle = a0;
    seg_ch.end_angle = a1;
    seg_ch.side_offset = off;
    do @(negedge clk); while (!seg_took);
  endtask

  // arc request with random pivot, margin k below the collapse edge (collapses if k >= 0)
  task automatic send_collapse(input logic [15:0] a0, a1, input longint r, k);
    longint sg;
    sg = ($signed(a1) >= $signed(a0)) ? 1 : -1;
    send_seg(1'b1, $urandom, $urandom, r[30:0], a0, a1, 32'(-sg * (r + k)));
  endtask

  task automatic send_random;
    logic [15:0] a0, a1;
    longint r, k;
    int mode;
    mode = $urandom_range(0, 9);
    a0 = 16'($urandom);
    case ($urandom_range(0, 4))
      0: a1 = a0;
      1: a1 = a0 + 16'h8000;
      2: a1 = 16'(a0 + $urandom_range(0, 8) - 4);
      default: a1 = 16'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) r = longint'($urandom & 32'h7fff_ffff);
    else r = longint'($urandom_range(0, 1 << 22));
    k = (r > 32'h3fff_ffff) ? 0 : longint'($urandom_range(0, 1 << $urandom_range(0, 24)));
    if (mode == 0) begin
      send_seg(1'b0, $urandom, $urandom, r[30:0], a0, a1, 32'(-r - k));
    end else if (mode == 1) begin
      send_seg(1'($urandom), $urandom, $urandom, 31'($urandom), 16'($urandom),
               16'($urandom), $urandom);
    end else if (mode == 2) begin
      send_collapse(a0, a1, r, -1);
    end else begin
      send_collapse(a0, a1, r, k);
    end
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    seg_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  initial begin
    rst = 1;
    quiet = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    seg_ch.valid = 0;
    seg_ch.is_arc = 0;
    seg_ch.pivot_x = '0;
    seg_ch.pivot_y = '0;
    seg_ch.arc_radius = '0;
    seg_ch.start_angle = '0;
    seg_ch.end_angle = '0;
    seg_ch.side_offset = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_seg(1'b0, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 16'h8000, 16'h7fff,
             32'h8000_0000);
    send_seg(1'b1, 32'h1_0000, 32'h2_0000, 31'h1_0000, 16'h0, 16'h4000, 32'h1_0000);
    send_collapse(16'h0, 16'h4000, 0, 0);
    send_collapse(16'h0, 16'h4000, 32'h1_0000, 0);
    send_collapse(16'h0, 16'h4000, 32'h1_0000, -1);
    send_collapse(16'h4000, 16'h0, 32'h1_0000, 32'h8000);
    send_collapse(16'h1000, 16'h1000, 32'h2_0000, 5);
    send_collapse(16'hc000, 16'h4000, 32'h2_0000, 5);
    send_collapse(16'h8000, 16'h7fff, 32'h100, 1);
    send_collapse(16'h7fff, 16'h8000, 32'h100, 1);
    send_collapse(16'h0, 16'h0001, 32'h10_0000, 32'h10_0000);
    send_collapse(16'h2000, 16'h2003, 32'h4000_0000, 32'h3fff_ffff);
    send_seg(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 16'h8000, 16'h7fff,
             32'h8000_0001);
    send_seg(1'b1, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 16'h7fff, 16'h8000,
             32'h7fff_ffff);
    send_seg(1'b1, 32'h7fff_ffff, 32'h8000_0000, 31'h0, 16'h0100, 16'h3f00,
             32'h8000_0000);
    send_seg(1'b1, 32'h0, 32'h0, 31'h0, 16'h0, 16'h0, 32'h0);

    set_threshold('0);
    repeat (150) send_random();
    set_threshold({THR_W{1'b1}});
    repeat (100) send_random();
    set_threshold(THR_W'($urandom_range(1 << 10, 1 << 28)));
    repeat (150) send_random();
    set_threshold(THR_RESET);
    repeat (100) send_random();
    quiet = 1;
    repeat (100) send_random();
    seg_ch.valid = 0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/oacc_pkg.sv
hw/rtl/oacc_if.sv
hw/rtl/oacc_cordic.sv
hw/rtl/oacc_front.sv
hw/rtl/oacc_fifo.sv
hw/rtl/oacc_div.sv
hw/rtl/oacc_back.sv
hw/rtl/offset_arc_corner_collapse.sv
bench/oacc_corner_checker.sv
bench/tb_top.sv
